// ----- sv/chi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chi_pkg
// Types and constants shared by the coalesced hash insert sequencer,
// datapath and top level.
// ----------------------------------------------------------------------------
package chi_pkg;

  localparam int CFG_W     = 9;
  localparam int KEY_W     = 32;
  localparam int KEY_IW    = 5;
  localparam int PAYLOAD_W = 64;
  localparam int SLOT_W    = 8;

  localparam logic [CFG_W-1:0] SIZE_RST = 9'd256;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              full_res;
  } result_t;

  // microprogram steps
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_HOME,
    S_HTEST,
    S_WALK,
    S_SPREP,
    S_SEARCH,
    S_LINK,
    S_STORE,
    S_FAIL
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_DONE,
    C_DIV_DONE,
    C_FREE,
    C_LINK_NULL,
    C_WALK_LIMIT,
    C_IDX_ZERO
  } cond_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_ITEM,
    W_RESULT
  } wait_t;

  typedef enum logic [2:0] {
    A_CNT,
    A_REM,
    A_TAIL,
    A_LINK,
    A_SZM1,
    A_IDXM1
  } asel_t;

  typedef struct packed {
    logic clr_wr;
    logic ld_item;
    logic div_step;
    logic cnt_inc;
    logic home_set;
    logic walk_adv;
    logic srch_init;
    logic srch_step;
    logic link_wr;
    logic store_wr;
    logic res_ok;
    logic res_fail;
  } op_t;

  typedef struct packed {
    wait_t wt;
    cond_t c1;
    step_t t1;
    cond_t c2;
    step_t t2;
    step_t tf;
    asel_t asel;
    op_t   op;
  } ucode_t;

  typedef struct packed {
    logic  go;
    asel_t asel;
    op_t   op;
  } dp_ctrl_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic free;
    logic link_null;
    logic walk_limit;
    logic idx_zero;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/chi_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chi_seq
// Microprogram sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module chi_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             result_free,
  input  chi_pkg::stat_t   stat,
  output logic             item_stall,
  output chi_pkg::dp_ctrl_t ctrl
);
  import chi_pkg::*;

  step_t  pc;
  step_t  pc_next;
  ucode_t uc;
  logic   go;

  function automatic ucode_t ucode(input step_t s);
    ucode_t u;
    u = '0;
    u.tf = s;
    case (s)
      S_CLEAR: begin
        u.asel = A_CNT;
        u.op.clr_wr = 1'b1;
        u.op.cnt_inc = 1'b1;
        u.c1 = C_CLR_DONE;
        u.t1 = S_IDLE;
      end
      S_IDLE: begin
        u.wt = W_ITEM;
        u.op.ld_item = 1'b1;
        u.c1 = C_ALWAYS;
        u.t1 = S_DIV;
      end
      S_DIV: begin
        u.op.div_step = 1'b1;
        u.op.cnt_inc = 1'b1;
        u.c1 = C_DIV_DONE;
        u.t1 = S_HOME;
      end
      S_HOME: begin
        u.asel = A_REM;
        u.op.home_set = 1'b1;
        u.tf = S_HTEST;
      end
      S_HTEST: begin
        u.asel = A_TAIL;
        u.c1 = C_FREE;
        u.t1 = S_STORE;
        u.tf = S_WALK;
      end
      S_WALK: begin
        u.asel = A_LINK;
        u.op.walk_adv = 1'b1;
        u.op.cnt_inc = 1'b1;
        u.c1 = C_LINK_NULL;
        u.t1 = S_SPREP;
        u.c2 = C_WALK_LIMIT;
        u.t2 = S_FAIL;
      end
      S_SPREP: begin
        u.asel = A_SZM1;
        u.op.srch_init = 1'b1;
        u.tf = S_SEARCH;
      end
      S_SEARCH: begin
        u.asel = A_IDXM1;
        u.op.srch_step = 1'b1;
        u.c1 = C_FREE;
        u.t1 = S_LINK;
        u.c2 = C_IDX_ZERO;
        u.t2 = S_FAIL;
      end
      S_LINK: begin
        u.asel = A_TAIL;
        u.op.link_wr = 1'b1;
        u.tf = S_STORE;
      end
      S_STORE: begin
        u.wt = W_RESULT;
        u.op.store_wr = 1'b1;
        u.op.res_ok = 1'b1;
        u.c1 = C_ALWAYS;
        u.t1 = S_IDLE;
      end
      S_FAIL: begin
        u.wt = W_RESULT;
        u.op.res_fail = 1'b1;
        u.c1 = C_ALWAYS;
        u.t1 = S_IDLE;
      end
      default: begin
        u.tf = S_IDLE;
      end
    endcase
    return u;
  endfunction

  function automatic logic test(input cond_t c, input stat_t st);
    logic r;
    r = 1'b0;
    case (c)
      C_NEVER:      r = 1'b0;
      C_ALWAYS:     r = 1'b1;
      C_CLR_DONE:   r = st.clr_done;
      C_DIV_DONE:   r = st.div_done;
      C_FREE:       r = st.free;
      C_LINK_NULL:  r = st.link_null;
      C_WALK_LIMIT: r = st.walk_limit;
      C_IDX_ZERO:   r = st.idx_zero;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  // control word and handshake outputs
  always_comb begin
    uc = ucode(pc);
    case (uc.wt)
      W_NONE:   go = 1'b1;
      W_ITEM:   go = item_valid;
      W_RESULT: go = result_free;
      default:  go = 1'b0;
    endcase
    item_stall = (uc.wt != W_ITEM);
    ctrl.go = go;
    ctrl.asel = uc.asel;
    ctrl.op = uc.op;
  end

  // next step: hold until the wait is met, then take the first true branch, else the fall-through step
  always_comb begin
    pc_next = pc;
    if (go) begin
      if (test(uc.c1, stat)) begin
        pc_next = uc.t1;
      end else if (test(uc.c2, stat)) begin
        pc_next = uc.t2;
      end else begin
        pc_next = uc.tf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/chi_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chi_dp
// Datapath: slot tables, bit-serial modulo, chain and free-slot registers.
// ----------------------------------------------------------------------------
module chi_dp #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  chi_pkg::dp_ctrl_t            ctrl,
  input  chi_pkg::item_t               item,
  input  logic [$clog2(DEPTH+1)-1:0]   size,
  output chi_pkg::stat_t               stat,
  output logic                         res_load,
  output chi_pkg::result_t             res
);
  import chi_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int SW   = $clog2(DEPTH+1);
  localparam int CNTW = (SW > KEY_IW) ? SW : KEY_IW;

  logic                 occ_mem [DEPTH];
  logic [AW:0]          lnk_mem [DEPTH];
  logic [KEY_W-1:0]     key_mem [DEPTH];
  logic [PAYLOAD_W-1:0] pay_mem [DEPTH];

  logic                 rocc;
  logic [AW:0]          rlnk;
  logic [CNTW-1:0]      cnt;
  logic [SW-1:0]        rem;
  logic [SW-1:0]        rem_next;
  logic [AW-1:0]        tail;
  logic [AW-1:0]        target;
  logic [AW-1:0]        idx;
  logic [KEY_W-1:0]     key_q;
  logic [PAYLOAD_W-1:0] pay_q;

  logic [AW-1:0]        addr;
  logic [AW-1:0]        sz_m1;
  logic [KEY_IW-1:0]    kidx;
  logic [SW:0]          trial;
  logic [SW:0]          sz_x;
  logic [SW:0]          diff;
  logic                 occ_we;
  logic [AW-1:0]        occ_wa;
  logic                 lnk_we;
  logic [AW-1:0]        lnk_wa;
  logic [AW:0]          lnk_wd;
  op_t                  op;

  assign op    = ctrl.op;
  assign sz_m1 = AW'(size - 1'b1);

  // restoring modulo, one key bit per step, MSB first
  assign kidx  = KEY_IW'(KEY_W-1) - cnt[KEY_IW-1:0];
  assign trial = {rem, key_q[kidx]};
  assign sz_x  = {1'b0, size};
  assign diff  = trial - sz_x;
  assign rem_next = (trial >= sz_x) ? diff[SW-1:0] : trial[SW-1:0];

  always_comb begin
    case (ctrl.asel)
      A_CNT:   addr = cnt[AW-1:0];
      A_REM:   addr = rem[AW-1:0];
      A_TAIL:  addr = tail;
      A_LINK:  addr = rlnk[AW-1:0];
      A_SZM1:  addr = sz_m1;
      A_IDXM1: addr = idx - 1'b1;
      default: addr = tail;
    endcase
  end

  always_comb begin
    occ_we = ctrl.go & (op.clr_wr | op.store_wr);
    occ_wa = op.clr_wr ? cnt[AW-1:0] : target;
    lnk_we = ctrl.go & (op.clr_wr | op.link_wr);
    lnk_wa = op.clr_wr ? cnt[AW-1:0] : tail;
    // top bit marks a null link
    lnk_wd = op.clr_wr ? {1'b1, {AW{1'b0}}} : {1'b0, target};
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= ~op.clr_wr;
    end
    rocc <= occ_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_wa] <= lnk_wd;
    end
    rlnk <= lnk_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && op.store_wr) begin
      key_mem[target] <= key_q;
      pay_mem[target] <= pay_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.go) begin
      if (op.ld_item || op.home_set) begin
        cnt <= '0;
      end else if (op.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      if (op.ld_item) begin
        key_q <= item.key;
        pay_q <= item.payload;
        rem   <= '0;
      end
      if (op.div_step) begin
        rem <= rem_next;
      end
      if (op.home_set) begin
        tail   <= rem[AW-1:0];
        target <= rem[AW-1:0];
      end
      // advance along the chain, hold at the tail
      if (op.walk_adv && !rlnk[AW]) begin
        tail <= rlnk[AW-1:0];
      end
      if (op.srch_init) begin
        idx <= sz_m1;
      end
      if (op.srch_step) begin
        target <= idx;
        idx    <= idx - 1'b1;
      end
    end
  end

  always_comb begin
    stat.clr_done   = (cnt == CNTW'(DEPTH-1));
    stat.div_done   = (cnt == CNTW'(KEY_W-1));
    stat.free       = ~rocc;
    stat.link_null  = rlnk[AW];
    stat.walk_limit = (cnt == CNTW'(DEPTH));
    stat.idx_zero   = (idx == '0);
  end

  assign res_load     = ctrl.go & (op.res_ok | op.res_fail);
  assign res.slot     = op.res_ok ? SLOT_W'(target) : '0;
  assign res.full_res = op.res_fail;

endmodule
`default_nettype wire

// ----- sv/coalesced_hash_insert.sv -----
`default_nettype none
// Sequence: after acceptance the bit-serial modulo picks the home slot; a free home
//   slot takes the word, else the chain is walked and a free slot is probed for.
// Flow: one word at a time; the next is taken once the sequencer is back in its
//   idle step after the result is registered. Cost is set by the 32-step bit-serial
//   modulo and by one table read per chain hop and per probe.
// Reset: clearing pass over all TABLE_DEPTH slots after rst, table_size = 256.
// ----------------------------------------------------------------------------
// coalesced_hash_insert
// Coalesced-chaining hash table insert driven by a microprogrammed sequencer.
// ----------------------------------------------------------------------------
module coalesced_hash_insert #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  chi_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output chi_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [chi_pkg::CFG_W-1:0]   cfg_data
);
  import chi_pkg::*;

  localparam int SW = $clog2(TABLE_DEPTH+1);
  localparam int XW = (SW > CFG_W) ? SW : CFG_W;

  logic [CFG_W-1:0] table_size;
  logic [XW-1:0]    ts_x;
  logic [SW-1:0]    size;
  logic             result_free;
  logic             res_load;
  result_t          res_w;
  dp_ctrl_t         ctrl;
  stat_t            stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RST;
    end else if (cfg_valid) begin
      table_size <= cfg_data;
    end
  end

  // clamp the size into one..TABLE_DEPTH
  always_comb begin
    ts_x = XW'(table_size);
    if (ts_x == '0) begin
      size = SW'(1);
    end else if (ts_x > XW'(TABLE_DEPTH)) begin
      size = SW'(TABLE_DEPTH);
    end else begin
      size = ts_x[SW-1:0];
    end
  end

  assign result_free = ~result_valid | ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_w;
    end
  end

  chi_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .result_free (result_free),
    .stat        (stat),
    .item_stall  (item_stall),
    .ctrl        (ctrl)
  );

  chi_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .item     (item),
    .size     (size),
    .stat     (stat),
    .res_load (res_load),
    .res      (res_w)
  );

endmodule
`default_nettype wire
